// ----- rtl/core/pmst_pkg.sv -----
// Shared types and constants for the Prim MST matrix unit.
// Used by pmst_ctrl, pmst_dpath and prim_mst_matrix_unit; no dependencies.
`default_nettype none

package pmst_pkg;

	localparam int DEF_MAX_NODES = 16;  // default store side
	localparam int NODE_CAP      = 16;  // output fields number nodes up to 16

	localparam int WEIGHT_W = 10;
	localparam int NODE_W   = 5;
	localparam int NUM_W    = 4;
	localparam int TOTAL_W  = 14;
	localparam int CNT_W    = 5;

	localparam logic [WEIGHT_W-1:0] NO_EDGE     = 10'd999;
	localparam logic [CNT_W-1:0]    RESET_NODES = 5'd16;

	// controller -> datapath
	typedef struct packed {
		logic load;       // request accepted, store one entry
		logic scan_init;  // start a round: rewind scan, best = infinity
		logic scan_step;  // issue one store read
		logic decide;     // act on best edge, clear first entry
		logic clear_b;    // clear mirror entry
		logic summary;    // emit summary, restart run state
		logic sum_disc;   // summary carries disconnected
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic load_last;    // current load completes the matrix
		logic rounds_left;  // spanning tree still incomplete (tree links < n-1)
		logic scan_last;    // read being issued is the final entry
		logic found;        // round found a finite edge
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/core/pmst_ctrl.sv -----
// Sequencer for the Prim MST matrix unit: load, scan rounds, clear, summary.
// Depends on pmst_pkg (cmd_t, status_t).
`default_nettype none

module pmst_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire pmst_pkg::status_t status,
	output pmst_pkg::cmd_t         cmd,
	output logic                   busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROUND,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_CLEAR,
		S_SUMMARY
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   disc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			disc_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start && status.load_last) begin
						state_q <= S_ROUND;
						busy_q  <= 1'b1;
					end
				end
				S_ROUND: begin
					if (status.rounds_left) begin
						state_q <= S_SCAN;
					end else begin
						disc_q  <= 1'b0;
						state_q <= S_SUMMARY;
					end
				end
				S_SCAN: begin
					if (status.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (status.found) begin
						state_q <= S_CLEAR;
					end else begin
						disc_q  <= 1'b1;
						state_q <= S_SUMMARY;
					end
				end
				S_CLEAR: begin
					state_q <= S_ROUND;
				end
				S_SUMMARY: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:    cmd.load      = start;
			S_ROUND:   cmd.scan_init = status.rounds_left;
			S_SCAN:    cmd.scan_step = 1'b1;
			S_DRAIN:   cmd           = '0;
			S_DECIDE:  cmd.decide    = status.found;
			S_CLEAR:   cmd.clear_b   = 1'b1;
			S_SUMMARY: begin
				cmd.summary  = 1'b1;
				cmd.sum_disc = disc_q;
			end
			default:   cmd           = '0;
		endcase
	end

	assign busy = busy_q;

endmodule

`default_nettype wire

// ----- rtl/core/pmst_dpath.sv -----
// Datapath of the Prim MST matrix unit: weight memory, scan, best-edge tracking,
// tree state and result registers. Depends on pmst_pkg.
`default_nettype none

module pmst_dpath #(
	parameter int MAX_NODES = pmst_pkg::DEF_MAX_NODES
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire pmst_pkg::cmd_t                 cmd,
	output pmst_pkg::status_t                   status,
	input  wire logic                           cfg_we,
	input  wire logic [pmst_pkg::CNT_W-1:0]     cfg_data,
	input  wire logic [pmst_pkg::WEIGHT_W-1:0]  edge_weight,
	output logic                                valid,
	output logic                                kind,
	output logic [pmst_pkg::NODE_W-1:0]         from_node,
	output logic [pmst_pkg::NODE_W-1:0]         to_node,
	output logic [pmst_pkg::WEIGHT_W-1:0]       edge_cost,
	output logic [pmst_pkg::NUM_W-1:0]          edge_number,
	output logic [pmst_pkg::TOTAL_W-1:0]        total_cost,
	output logic                                disconnected,
	output logic                                last
);

	localparam int NL    = (MAX_NODES < pmst_pkg::NODE_CAP) ? MAX_NODES : pmst_pkg::NODE_CAP;
	localparam int IW    = $clog2(NL);        // node index
	localparam int NW    = IW + 1;            // node count
	localparam int DEPTH = NL * NL;           // reachable part of the matrix
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = $clog2(DEPTH + 1);
	localparam int CW    = 2 * NW;
	localparam int PW    = 2 * IW + 1;
	localparam int WW    = pmst_pkg::WEIGHT_W;

	logic [WW-1:0] mem [DEPTH];

	logic [pmst_pkg::CNT_W-1:0]   node_count_q;
	logic [NW-1:0]                nin;
	logic [CW-1:0]                square;
	logic [LW-1:0]                load_pos_q;
	logic                         load_hit;
	logic [NW-1:0]                n_q;
	logic [IW-1:0]                nlast;
	logic [NL-1:0]                visited_q;
	logic [pmst_pkg::NUM_W-1:0]   edges_q;
	logic [pmst_pkg::TOTAL_W-1:0] cost_q;

	logic [AW-1:0]                addr_q;
	logic [IW-1:0]                i_q, j_q;
	logic                         vld_s1, vis_s1;
	logic [IW-1:0]                i_s1, j_s1;
	logic [WW-1:0]                rdata_s1;
	logic [WW-1:0]                eff;
	logic                         take;
	logic [WW-1:0]                best_q;
	logic [IW-1:0]                bu_q, bv_q;

	logic                         emit_edge;
	logic [pmst_pkg::NUM_W-1:0]   edges_nxt;
	logic [pmst_pkg::TOTAL_W-1:0] cost_nxt;
	logic [PW-1:0]                prod_a, prod_b;
	logic [AW-1:0]                addr_a, addr_b;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [WW-1:0]                wr_data;

	logic                         valid_q;

	// node count in use, limited to 1..NL
	always_comb begin
		priority if (node_count_q == '0) begin
			nin = NW'(1);
		end else if (node_count_q > pmst_pkg::CNT_W'(NL)) begin
			nin = NW'(NL);
		end else begin
			nin = NW'(node_count_q);
		end
	end

	assign square   = CW'(nin) * CW'(nin);
	assign load_hit = CW'(load_pos_q) < square;
	assign nlast    = IW'(n_q - NW'(1));

	assign status.load_last   = (CW'(load_pos_q) + CW'(1)) >= square;
	assign status.rounds_left = (5'({1'b0, edges_q}) + 5'd1) < 5'(n_q);
	assign status.scan_last   = (i_q == nlast) && (j_q == nlast);
	assign status.found       = best_q != pmst_pkg::NO_EDGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= pmst_pkg::RESET_NODES;
		end else if (cfg_we) begin
			node_count_q <= cfg_data;
		end
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			visited_q  <= NL'(1);
			edges_q    <= '0;
			cost_q     <= '0;
			n_q        <= NW'(1);
		end else begin
			if (cmd.load) begin
				load_pos_q <= load_pos_q + LW'(1);
				if (status.load_last) begin
					n_q <= nin;
				end
			end
			if (emit_edge) begin
				visited_q[bv_q] <= 1'b1;
				edges_q         <= edges_nxt;
				cost_q          <= cost_nxt;
			end
			if (cmd.summary) begin
				load_pos_q <= '0;
				visited_q  <= NL'(1);
				edges_q    <= '0;
				cost_q     <= '0;
			end
		end
	end

	// row-major scan over the whole matrix, rows of unvisited nodes masked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			addr_q <= '0;
			i_q    <= '0;
			j_q    <= '0;
		end else if (cmd.scan_step) begin
			addr_q <= addr_q + AW'(1);
			if (j_q == nlast) begin
				j_q <= '0;
				i_q <= i_q + IW'(1);
			end else begin
				j_q <= j_q + IW'(1);
			end
		end
		vis_s1 <= visited_q[i_q];
		i_s1   <= i_q;
		j_s1   <= j_q;
	end

	assign eff  = (rdata_s1 == '0 || rdata_s1 >= pmst_pkg::NO_EDGE) ? pmst_pkg::NO_EDGE
	                                                               : rdata_s1;
	assign take = vld_s1 && vis_s1 && (eff < best_q);

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			best_q <= pmst_pkg::NO_EDGE;
		end else if (take) begin
			best_q <= eff;
			bu_q   <= i_s1;
			bv_q   <= j_s1;
		end
	end

	// chosen entry and its mirror
	assign prod_a = PW'(bu_q) * PW'(n_q);
	assign prod_b = PW'(bv_q) * PW'(n_q);
	assign addr_a = AW'(prod_a + PW'(bv_q));
	assign addr_b = AW'(prod_b + PW'(bu_q));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_a;
		wr_data = pmst_pkg::NO_EDGE;
		priority if (cmd.load) begin
			wr_en   = load_hit;
			wr_addr = load_pos_q[AW-1:0];
			wr_data = edge_weight;
		end else if (cmd.decide) begin
			wr_en   = 1'b1;
		end else if (cmd.clear_b) begin
			wr_en   = 1'b1;
			wr_addr = addr_b;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[addr_q];
	end

	// results
	assign emit_edge = cmd.decide && !visited_q[bv_q];
	assign edges_nxt = edges_q + pmst_pkg::NUM_W'(1);
	assign cost_nxt  = cost_q + pmst_pkg::TOTAL_W'(best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= emit_edge || cmd.summary;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_edge) begin
			kind         <= 1'b0;
			from_node    <= pmst_pkg::NODE_W'(bu_q) + pmst_pkg::NODE_W'(1);
			to_node      <= pmst_pkg::NODE_W'(bv_q) + pmst_pkg::NODE_W'(1);
			edge_cost    <= best_q;
			edge_number  <= edges_nxt;
			total_cost   <= cost_nxt;
			disconnected <= 1'b0;
			last         <= 1'b0;
		end else if (cmd.summary) begin
			kind         <= 1'b1;
			from_node    <= '0;
			to_node      <= '0;
			edge_cost    <= '0;
			edge_number  <= '0;
			total_cost   <= cost_q;
			disconnected <= cmd.sum_disc;
			last         <= 1'b1;
		end
	end

	assign valid = valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/prim_mst_matrix_unit.sv -----
// Top level of the Prim MST matrix unit: controller plus datapath, checks.
// Depends on pmst_pkg, pmst_ctrl and pmst_dpath.
//
//  port group       dir  handshake           payload
//  request          in   start & !busy       edge_weight
//  result           out  valid (one cycle)   kind, from_node, to_node, edge_cost,
//                                            edge_number, total_cost,
//                                            disconnected, last
//  config           in   cfg_we              cfg_data (node_count)
//
// Load: one matrix entry per cycle, n*n requests in row-major order.
// After the last entry busy rises. Each round has a setup step, one
// read of the single-port weight memory per entry, a step for the last
// compare, one to act on the edge and, if one was found, one to clear its
// mirror. Every round that finds an edge clears a different node pair
// (self loops included), so a run is at most n*(n+1)/2 + 1 rounds, then the
// summary result. Rounds on self loops or visited pairs emit nothing.
// The summary strobe comes in the first cycle with busy low again.
// Reset (arst_n low) clears the run state, node_count goes to 16; the
// weight memory is not cleared. Results cannot be held off by the receiver.
`default_nettype none

module prim_mst_matrix_unit #(
	parameter int MAX_NODES = pmst_pkg::DEF_MAX_NODES
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [pmst_pkg::WEIGHT_W-1:0]  edge_weight,
	input  wire logic                           cfg_we,
	input  wire logic [pmst_pkg::CNT_W-1:0]     cfg_data,
	output logic                                valid,
	output logic                                kind,
	output logic [pmst_pkg::NODE_W-1:0]         from_node,
	output logic [pmst_pkg::NODE_W-1:0]         to_node,
	output logic [pmst_pkg::WEIGHT_W-1:0]       edge_cost,
	output logic [pmst_pkg::NUM_W-1:0]          edge_number,
	output logic [pmst_pkg::TOTAL_W-1:0]        total_cost,
	output logic                                disconnected,
	output logic                                last
);

	pmst_pkg::cmd_t    cmd;
	pmst_pkg::status_t status;

	// sequencer: owns busy and the round structure
	pmst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// memory, scan and result registers
	pmst_dpath #(
		.MAX_NODES (MAX_NODES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.edge_weight  (edge_weight),
		.valid        (valid),
		.kind         (kind),
		.from_node    (from_node),
		.to_node      (to_node),
		.edge_cost    (edge_cost),
		.edge_number  (edge_number),
		.total_cost   (total_cost),
		.disconnected (disconnected),
		.last         (last)
	);

	// tree edges only come out while a run is in progress
	a_edge_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !kind) |-> busy)
		else $error("edge result outside a run");

	// the summary closes the run
	a_summary_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && kind) |-> (last && !busy && $fell(busy)))
		else $error("summary not at end of run");

	// at least the round setup cycle separates two results
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid)
		else $error("results in consecutive cycles");

	// a run only begins on an accepted request
	a_run_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without request");

endmodule

`default_nettype wire
